/* rtl/core/ffha_pkg.sv */
// Shared types and constants of the first-fit heap allocator.
// No dependencies; ffha_alu, ffha_seq and the top level import this package.
package ffha_pkg;

    localparam int DATA_W = 32;
    localparam int REQ_W = 17;
    localparam int NEED_W = REQ_W + 1;

    localparam logic [DATA_W-1:0] BASE_RESET = 32'h0080_0000;
    localparam logic [3:0] NEED_PAD = 4'd11;
    localparam logic [3:0] HDR_GAP = 4'd8;
    localparam logic REG_HEAP_BASE = 1'b0;

    typedef enum logic [1:0] {
        HDR_FREE = 2'd0,
        HDR_USED = 2'd1,
        HDR_END  = 2'd2
    } t_hdr_state;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_NEED,
        ST_RD,
        ST_CHK,
        ST_ADV,
        ST_NXT,
        ST_REM,
        ST_WSPL,
        ST_WEND,
        ST_WUSE,
        ST_FOFF,
        ST_FRD,
        ST_FCHK
    } t_state;

    typedef struct packed {
        logic              sub;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [3:0]        k;
    } t_alu_req;

endpackage

/* rtl/core/ffha_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ffha_alu.sv */
// Shared adder and subtractor of the allocator, one operation per cycle.
// Depends on ffha_pkg for the request type.
module ffha_alu
    import ffha_pkg::*;
(
    input  t_alu_req          i_req,
    output logic [DATA_W:0]   o_res
);

    logic [DATA_W:0] w_b;
    logic [DATA_W:0] w_cin;

    // Subtraction yields the borrow in the top bit.
    assign w_b   = i_req.sub ? ~{1'b0, i_req.b} : {1'b0, i_req.b};
    assign w_cin = i_req.sub ? (DATA_W+1)'(1) : (DATA_W+1)'(i_req.k);
    assign o_res = {1'b0, i_req.a} + w_b + w_cin;

endmodule

/* rtl/core/ffha_seq.sv */
// Sequencer of the allocator: walks the header chain and updates headers.
// Depends on ffha_pkg; drives the shared ALU and the header RAM.
module ffha_seq
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_kind,
    input  logic [REQ_W-1:0]               i_request_size,
    input  logic [DATA_W-1:0]              i_block_address,
    input  logic [DATA_W-1:0]              i_heap_base,
    output logic                           o_busy,
    output t_alu_req                       o_alu_req,
    input  logic [DATA_W:0]                i_alu_res,
    output logic                           o_ram_en,
    output logic                           o_ram_we,
    output logic [$clog2(HEAP_BYTES)-3:0]  o_ram_addr,
    output logic [$clog2(HEAP_BYTES)+2:0]  o_ram_wdata,
    input  logic [$clog2(HEAP_BYTES)+2:0]  i_ram_rdata,
    output logic                           o_done,
    output logic [DATA_W-1:0]              o_result_address,
    output logic                           o_status
);

    localparam int OW = $clog2(HEAP_BYTES);
    localparam int SW = OW + 1;
    localparam int PW = OW + 2;
    localparam logic [PW-1:0] P_LIMIT = PW'(HEAP_BYTES);
    localparam logic [DATA_W:0] R_LIMIT = (DATA_W+1)'(HEAP_BYTES);

    t_state r_state, n_state;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [DATA_W-1:0] r_addr, n_addr;
    logic [NEED_W-1:0] r_need, n_need;
    logic [PW-1:0]     r_p, n_p;
    logic [SW-1:0]     r_size, n_size;
    logic [SW-1:0]     r_diff, n_diff;
    logic [SW-1:0]     r_rem, n_rem;
    logic [OW-1:0]     r_nxt, n_nxt;
    logic              r_is_end, n_is_end;
    logic              r_cut, n_cut;
    logic              r_done, n_done;
    logic [DATA_W-1:0] r_result, n_result;
    logic              r_status, n_status;

    t_hdr_state        w_hdr;
    logic [SW-1:0]     w_hdr_size;
    logic              w_accept;
    logic              w_p_fits;
    logic              w_res_fits;
    logic              w_off_fits;
    logic              w_split;

    assign w_hdr      = t_hdr_state'(i_ram_rdata[SW+1:SW]);
    assign w_hdr_size = i_ram_rdata[SW-1:0];
    assign w_accept   = i_start && (r_state == ST_IDLE);
    assign w_p_fits   = (r_p[1:0] == 2'b00) && (r_p < P_LIMIT);
    assign w_res_fits = i_alu_res < R_LIMIT;
    assign w_off_fits = (i_alu_res[1:0] == 2'b00) && ({1'b0, i_alu_res[DATA_W-1:0]} < R_LIMIT);
    assign w_split    = i_alu_res[DATA_W] || (i_alu_res[DATA_W-1:0] > DATA_W'(HDR_GAP));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: n_state = ST_IDLE;
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_kind ? ST_FOFF : ST_NEED;
                end
            end
            ST_NEED: n_state = ST_RD;
            ST_RD:   n_state = w_p_fits ? ST_CHK : ST_IDLE;
            ST_CHK: begin
                if (w_hdr == HDR_USED || (w_hdr == HDR_FREE && i_alu_res[DATA_W])) begin
                    n_state = ST_ADV;
                end else if (w_hdr == HDR_END) begin
                    n_state = ST_NXT;
                end else begin
                    n_state = w_split ? ST_NXT : ST_WUSE;
                end
            end
            ST_ADV:  n_state = ST_RD;
            ST_NXT: begin
                if (w_res_fits) begin
                    n_state = r_is_end ? ST_WEND : ST_REM;
                end else begin
                    n_state = r_is_end ? ST_IDLE : ST_WUSE;
                end
            end
            ST_REM:  n_state = ST_WSPL;
            ST_WSPL: n_state = ST_WUSE;
            ST_WEND: n_state = ST_WUSE;
            ST_WUSE: n_state = ST_IDLE;
            ST_FOFF: n_state = w_off_fits ? ST_FRD : ST_IDLE;
            ST_FRD:  n_state = ST_FCHK;
            ST_FCHK: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_alu_req   = '0;
        o_ram_en    = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = r_p[OW-1:2];
        o_ram_wdata = '0;
        n_req       = r_req;
        n_addr      = r_addr;
        n_need      = r_need;
        n_p         = r_p;
        n_size      = r_size;
        n_diff      = r_diff;
        n_rem       = r_rem;
        n_nxt       = r_nxt;
        n_is_end    = r_is_end;
        n_cut       = r_cut;
        n_done      = 1'b0;
        n_result    = r_result;
        n_status    = r_status;
        unique case (r_state)
            ST_INIT: begin
                o_ram_en    = 1'b1;
                o_ram_we    = 1'b1;
                o_ram_addr  = '0;
                o_ram_wdata = {HDR_END, SW'(0)};
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_req  = i_request_size;
                    n_addr = i_block_address;
                end
            end
            ST_NEED: begin
                o_alu_req.a = DATA_W'(r_req);
                o_alu_req.k = NEED_PAD;
                n_need      = {i_alu_res[NEED_W-1:2], 2'b00};
                n_p         = '0;
            end
            ST_RD: begin
                if (w_p_fits) begin
                    o_ram_en = 1'b1;
                end else begin
                    n_done   = 1'b1;
                    n_result = '0;
                    n_status = 1'b1;
                end
            end
            ST_CHK: begin
                o_alu_req.sub = 1'b1;
                o_alu_req.a   = DATA_W'(w_hdr_size);
                o_alu_req.b   = DATA_W'(r_need);
                n_size        = w_hdr_size;
                n_diff        = i_alu_res[SW-1:0];
                n_is_end      = (w_hdr == HDR_END);
                n_cut         = 1'b0;
            end
            ST_ADV: begin
                o_alu_req.a = DATA_W'(r_p);
                o_alu_req.b = DATA_W'(r_size);
                o_alu_req.k = HDR_GAP;
                n_p         = i_alu_res[PW-1:0];
            end
            ST_NXT: begin
                o_alu_req.a = DATA_W'(r_p);
                o_alu_req.b = DATA_W'(r_need);
                o_alu_req.k = HDR_GAP;
                n_nxt       = i_alu_res[OW-1:0];
                if (!w_res_fits && r_is_end) begin
                    n_done   = 1'b1;
                    n_result = '0;
                    n_status = 1'b1;
                end
            end
            ST_REM: begin
                o_alu_req.sub = 1'b1;
                o_alu_req.a   = DATA_W'(r_diff);
                o_alu_req.b   = DATA_W'(HDR_GAP);
                n_rem         = i_alu_res[SW-1:0];
            end
            ST_WSPL: begin
                o_ram_en    = 1'b1;
                o_ram_we    = 1'b1;
                o_ram_addr  = r_nxt[OW-1:2];
                o_ram_wdata = {HDR_FREE, r_rem};
                n_cut       = 1'b1;
            end
            ST_WEND: begin
                o_ram_en    = 1'b1;
                o_ram_we    = 1'b1;
                o_ram_addr  = r_nxt[OW-1:2];
                o_ram_wdata = {HDR_END, SW'(0)};
                n_cut       = 1'b1;
            end
            ST_WUSE: begin
                o_ram_en    = 1'b1;
                o_ram_we    = 1'b1;
                o_ram_wdata = {HDR_USED, r_cut ? SW'(r_need) : r_size};
                o_alu_req.a = i_heap_base;
                o_alu_req.b = DATA_W'(r_p);
                n_done      = 1'b1;
                n_result    = i_alu_res[DATA_W-1:0];
                n_status    = 1'b0;
            end
            ST_FOFF: begin
                o_alu_req.sub = 1'b1;
                o_alu_req.a   = r_addr;
                o_alu_req.b   = i_heap_base;
                n_p           = PW'(i_alu_res[OW-1:0]);
                if (!w_off_fits) begin
                    n_done   = 1'b1;
                    n_result = r_addr;
                    n_status = 1'b1;
                end
            end
            ST_FRD: begin
                o_ram_en = 1'b1;
            end
            ST_FCHK: begin
                n_done   = 1'b1;
                n_result = r_addr;
                if (w_hdr == HDR_END) begin
                    n_status = 1'b1;
                end else begin
                    o_ram_en    = 1'b1;
                    o_ram_we    = 1'b1;
                    o_ram_wdata = {HDR_FREE, w_hdr_size};
                    n_status    = 1'b0;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_addr   <= n_addr;
        r_need   <= n_need;
        r_p      <= n_p;
        r_size   <= n_size;
        r_diff   <= n_diff;
        r_rem    <= n_rem;
        r_nxt    <= n_nxt;
        r_is_end <= n_is_end;
        r_cut    <= n_cut;
        r_result <= n_result;
        r_status <= n_status;
    end

    assign o_busy           = (r_state != ST_IDLE);
    assign o_done           = r_done;
    assign o_result_address = r_result;
    assign o_status         = r_status;

endmodule

/* rtl/core/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: APB register, sequencer, ALU, header RAM.
// Depends on ffha_pkg, ffha_ram, ffha_alu and ffha_seq.
//
// Channel   Direction  Handshake                    Word
// request   in         start high while busy low    i_kind, i_request_size, i_block_address
// result    out        o_done strobe, one cycle     o_result_address, o_status
// config    in         psel, penable, pwrite        paddr, pwdata, prdata (heap_base)
//
// A free passes through the offset check, the header read and the header check after
// acceptance, and ends after the offset check when its address is refused. An allocation
// rounds the size, then for each header it passes reads the RAM, compares and advances
// through the shared ALU, and then finishes, all on the single header RAM port. The result
// strobe comes in the cycle after the last busy cycle. After reset the block writes the
// end marker at offset 0 with busy high. Results cannot be stalled.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_kind,
    input  logic [REQ_W-1:0]    i_request_size,
    input  logic [DATA_W-1:0]   i_block_address,
    output logic                o_done,
    output logic [DATA_W-1:0]   o_result_address,
    output logic                o_status,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    localparam int OW = $clog2(HEAP_BYTES);
    localparam int HW = OW + 3;
    localparam int DEPTH = HEAP_BYTES / 4;

    logic [DATA_W-1:0] r_heap_base;
    t_alu_req          w_alu_req;
    logic [DATA_W:0]   w_alu_res;
    logic              w_ram_en;
    logic              w_ram_we;
    logic [OW-3:0]     w_ram_addr;
    logic [HW-1:0]     w_ram_wdata;
    logic [HW-1:0]     w_ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= BASE_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_HEAP_BASE) begin
            r_heap_base <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HEAP_BASE) ? r_heap_base : '0;

    ffha_seq #(
        .HEAP_BYTES(HEAP_BYTES)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_kind          (i_kind),
        .i_request_size  (i_request_size),
        .i_block_address (i_block_address),
        .i_heap_base     (r_heap_base),
        .o_busy          (busy),
        .o_alu_req       (w_alu_req),
        .i_alu_res       (w_alu_res),
        .o_ram_en        (w_ram_en),
        .o_ram_we        (w_ram_we),
        .o_ram_addr      (w_ram_addr),
        .o_ram_wdata     (w_ram_wdata),
        .i_ram_rdata     (w_ram_rdata),
        .o_done          (o_done),
        .o_result_address(o_result_address),
        .o_status        (o_status)
    );

    ffha_alu u_alu (
        .i_req(w_alu_req),
        .o_res(w_alu_res)
    );

    ffha_ram #(
        .WIDTH(HW),
        .DEPTH(DEPTH)
    ) u_hdr_ram (
        .i_clk  (i_clk),
        .i_en   (w_ram_en),
        .i_we   (w_ram_we),
        .i_addr (w_ram_addr),
        .i_wdata(w_ram_wdata),
        .o_rdata(w_ram_rdata)
    );

endmodule
